// File: rtl/core/tsbe_pkg.sv
`default_nettype none
package tsbe_pkg;

    localparam int MESSAGE_BITS_DEF = 256;
    localparam int FRAME_TICKS      = 10;
    localparam int STUFF_RUN        = 8;
    localparam int MIN_SYNC_FRAMES  = 3;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_COMMIT = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] bit_position;
        logic       bit_value;
        logic [7:0] message_length;
    } t_in_item;

    typedef struct packed {
        logic track_level;
        logic sending_data;
        logic message_done;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_WRITE,
        CMD_COMMIT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] pos;
        logic       value;
        logic [7:0] len;
    } t_cmd;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

endpackage
`default_nettype wire

// File: rtl/core/tsbe_front.sv
`default_nettype none
module tsbe_front
    import tsbe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output t_queue_head o_head,
    input  wire         i_pop
);

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       cls;
    logic       cls_ok;
    logic       push;
    logic       pop;

    // classify; unknown action is dropped at the door
    always_comb begin
        cls.pos   = i_in.bit_position;
        cls.value = i_in.bit_value;
        cls.len   = i_in.message_length;
        cls_ok    = 1'b1;
        case (i_in.action)
            ACT_TICK:   cls.kind = CMD_TICK;
            ACT_WRITE:  cls.kind = CMD_WRITE;
            ACT_COMMIT: cls.kind = CMD_COMMIT;
            default: begin
                cls.kind = CMD_TICK;
                cls_ok   = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == 2'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall && cls_ok;
    assign pop        = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tsbe_back.sv
`default_nettype none
module tsbe_back
    import tsbe_pkg::*;
#(
    parameter int MESSAGE_BITS = MESSAGE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_run_enable,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_item   o_out
);

    localparam int AW = (MESSAGE_BITS > 1) ? $clog2(MESSAGE_BITS) : 1;

    logic       r_mem [MESSAGE_BITS];
    logic       r_mem_q;
    logic       r_rd_ok;
    logic       r_byp_en;
    logic       r_byp_val;

    logic       r_level,     n_level;
    logic [3:0] r_tick,      n_tick;
    logic [7:0] r_sfd,       n_sfd;
    logic [3:0] r_ones,      n_ones;
    logic       r_pending,   n_pending;
    logic       r_data_mode, n_data_mode;
    logic       r_at_start,  n_at_start;
    logic       r_stuff,     n_stuff;
    logic [7:0] r_cur,       n_cur;
    logic [7:0] r_left,      n_left;
    logic [7:0] r_plen,      n_plen;

    logic       r_out_valid;
    t_out_item  r_out;

    logic       slot_free;
    logic       do_tick;
    logic       wr_en;
    logic       rd_ok;
    logic       cur_bit;
    logic       sending;
    logic       done;
    logic [3:0] tick_inc;
    logic [3:0] ones_inc;
    logic [7:0] sfd_inc;
    logic [7:0] left_dec;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = i_head.valid && ((i_head.cmd.kind != CMD_TICK) || slot_free);
    assign do_tick   = o_pop && (i_head.cmd.kind == CMD_TICK);
    assign wr_en     = o_pop && (i_head.cmd.kind == CMD_WRITE)
                       && ({1'b0, i_head.cmd.pos} < 9'(MESSAGE_BITS));
    assign cur_bit   = r_rd_ok && (r_byp_en ? r_byp_val : r_mem_q);

    assign tick_inc = r_tick + 4'd1;
    assign ones_inc = r_ones + 4'd1;
    assign sfd_inc  = (r_sfd != 8'hFF) ? r_sfd + 8'd1 : r_sfd;
    assign left_dec = r_left - 8'd1;

    always_comb begin
        n_level     = r_level;
        n_tick      = r_tick;
        n_sfd       = r_sfd;
        n_ones      = r_ones;
        n_pending   = r_pending;
        n_data_mode = r_data_mode;
        n_at_start  = r_at_start;
        n_stuff     = r_stuff;
        n_cur       = r_cur;
        n_left      = r_left;
        n_plen      = r_plen;
        sending     = 1'b0;
        done        = 1'b0;

        if (o_pop && (i_head.cmd.kind == CMD_COMMIT)) begin
            n_plen    = i_head.cmd.len;
            n_pending = 1'b1;
        end

        if (do_tick && i_run_enable) begin
            if (r_data_mode) begin
                sending = 1'b1;
                if (r_at_start) begin
                    n_level    = ~r_level;
                    n_at_start = 1'b0;
                end else begin
                    n_at_start = 1'b1;
                    if (r_stuff) begin
                        n_stuff = 1'b0;
                        n_ones  = 4'd0;
                    end else begin
                        if (cur_bit) begin
                            n_level = ~r_level;
                            n_ones  = ones_inc;
                            if (ones_inc >= 4'(STUFF_RUN)) begin
                                n_ones  = 4'd0;
                                n_stuff = 1'b1;
                            end
                        end else begin
                            n_ones = 4'd0;
                        end
                        n_cur  = r_cur + 8'd1;
                        n_left = left_dec;
                        if (left_dec == 8'd0) begin
                            // last bit: no trailing stuff cell
                            n_data_mode = 1'b0;
                            n_stuff     = 1'b0;
                            n_at_start  = 1'b0;
                            n_tick      = 4'd0;
                            done        = 1'b1;
                        end
                    end
                end
            end else begin
                n_tick = tick_inc;
                if (tick_inc inside {4'd1, 4'd3, 4'd4, 4'd6, 4'd8, 4'd9}) begin
                    n_level = ~r_level;
                end
                if (tick_inc >= 4'(FRAME_TICKS)) begin
                    n_tick = 4'd0;
                    if (r_pending && (r_sfd > 8'(MIN_SYNC_FRAMES))) begin
                        n_pending = 1'b0;
                        if (r_plen != 8'd0) begin
                            n_sfd       = 8'd0;
                            n_ones      = 4'd0;
                            n_stuff     = 1'b0;
                            n_at_start  = 1'b1;
                            n_cur       = 8'd1;
                            n_left      = r_plen;
                            n_data_mode = 1'b1;
                        end else begin
                            n_sfd = sfd_inc;
                        end
                    end else begin
                        n_sfd = sfd_inc;
                    end
                end
            end
        end
    end

    assign rd_ok = ({1'b0, n_cur} < 9'(MESSAGE_BITS));

    // keep a registered copy of the entry at the next bit index, with write bypass
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_head.cmd.pos[AW-1:0]] <= i_head.cmd.value;
        end
        r_mem_q   <= r_mem[n_cur[AW-1:0]];
        r_rd_ok   <= rd_ok;
        r_byp_en  <= wr_en && (i_head.cmd.pos == n_cur);
        r_byp_val <= i_head.cmd.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= 1'b1;
            r_tick      <= 4'd0;
            r_sfd       <= 8'd0;
            r_ones      <= 4'd0;
            r_pending   <= 1'b0;
            r_data_mode <= 1'b0;
            r_at_start  <= 1'b0;
            r_stuff     <= 1'b0;
            r_cur       <= 8'd0;
            r_left      <= 8'd0;
            r_plen      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_level     <= n_level;
            r_tick      <= n_tick;
            r_sfd       <= n_sfd;
            r_ones      <= n_ones;
            r_pending   <= n_pending;
            r_data_mode <= n_data_mode;
            r_at_start  <= n_at_start;
            r_stuff     <= n_stuff;
            r_cur       <= n_cur;
            r_left      <= n_left;
            r_plen      <= n_plen;
            if (do_tick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_tick) begin
            r_out.track_level  <= n_level;
            r_out.sending_data <= sending;
            r_out.message_done <= done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_done_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.message_done |-> r_out.sending_data)
        else $error("message_done without sending_data");
    a_frame_cleared_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_mode |-> (r_tick == 4'd0))
        else $error("frame tick not cleared in data mode");
    a_stuff_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuff |-> r_data_mode)
        else $error("stuff cell pending outside data mode");
    a_ones_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones < 4'(STUFF_RUN))
        else $error("ones run passed the stuffing limit");
`endif

endmodule
`default_nettype wire

// File: rtl/core/track_signal_sync_and_bit_encoder.sv
`default_nettype none
// A tick's result is registered in the output register when the back end retires that tick from the queue.
// Throughput: one transaction per cycle while o_in_stall is low; the back end retires one queued command
// each cycle, a tick only when the output register is free or being taken.
// Reset (synchronous, active low): level high, sync mode, queue and output empty,
// run_enable cleared; message store contents stay undefined until written.
module track_signal_sync_and_bit_encoder
    import tsbe_pkg::*;
#(
    parameter int MESSAGE_BITS = MESSAGE_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_item  o_out,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata
);

    logic        r_run_enable;
    t_queue_head head;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_run_enable <= i_cfg_wdata;
        end
    end

    tsbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_head     (head),
        .i_pop      (pop)
    );

    tsbe_back #(
        .MESSAGE_BITS (MESSAGE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run_enable (r_run_enable),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire
